[rtl/sgf_pkg.sv]
package sgf_pkg;

   localparam int MaxCols = 64;
   localparam int MaxRows = 64;
   localparam int Ghost = 3;
   localparam int PadCols = MaxCols + 2 * Ghost;
   localparam int PadRows = MaxRows + 2 * Ghost;
   localparam int Depth = PadCols * PadRows;
   localparam int AddrW = $clog2(Depth);

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_APPLY = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_PERIODIC = 2'd1;
   localparam logic [1:0] MODE_MIRROR = 2'd2;
   localparam logic [1:0] MODE_FIXED = 2'd3;

   localparam logic [2:0] REG_GRID_KIND = 3'd0;
   localparam logic [2:0] REG_SIDE_MODES = 3'd1;
   localparam logic [2:0] REG_COLS = 3'd2;
   localparam logic [2:0] REG_ROWS = 3'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] col;
      logic [6:0] row;
      logic signed [31:0] cell_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic position_error;
   } rsp_type;

   // one step of a fill: copy, fixed value, or 2c minus source
   typedef struct packed {
      logic valid;
      logic [7:0] di;
      logic [7:0] dj;
      logic [7:0] si;
      logic [7:0] sj;
      logic [1:0] op;
      logic signed [31:0] c;
   } step_type;

   localparam logic [1:0] OP_COPY = 2'd0;
   localparam logic [1:0] OP_PUT = 2'd1;
   localparam logic [1:0] OP_ANTI = 2'd2;

   function automatic logic [AddrW-1:0] cell_addr(input logic [7:0] i, input logic [7:0] j);
      logic [AddrW+8:0] a;
      a = (AddrW+9)'(i) * (AddrW+9)'(PadRows) + (AddrW+9)'(j);
      return a[AddrW-1:0];
   endfunction

   function automatic logic inside_pad(input logic [7:0] i, input logic [7:0] j);
      return (i < 8'(PadCols)) && (j < 8'(PadRows));
   endfunction

endpackage

[rtl/staggered_grid_ghost_cell_fill.sv]
// Ghost-cell fill for a padded 2D staggered field held in one block RAM.
// A write or read item passes through the ACCESS state for the RAM access, and
// its result is then registered. An apply item walks every ghost cell of the
// enabled sides through WALK_RD, WALK_WAIT and WALK_WR for each cell (read
// source, wait for data, modify and write back), passes over each of the eight
// side phases, skipped ones included, and ends in FINISH; busy stays
// high meanwhile.
// Results appear on rsp_valid for one cycle and cannot be stalled.
module staggered_grid_ghost_cell_fill (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sgf_pkg::req_type  req_data,
   output logic              rsp_valid,
   output sgf_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);
   typedef enum logic [2:0] {
      IDLE,
      ACCESS,
      WALK_RD,
      WALK_WAIT,
      WALK_WR,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] grid_kind_ff;
   logic [7:0] side_modes_ff;
   logic [6:0] cols_ff, rows_ff;
   logic signed [31:0] side_value_ff [4];
   sgf_pkg::req_type req_ff;
   logic bad_ff;
   logic rsp_valid_ff;
   sgf_pkg::rsp_type rsp_ff;
   sgf_pkg::step_type step_ff;

   logic [7:0] nx, ny;
   logic bad;
   logic wr_en;
   logic [sgf_pkg::AddrW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;
   sgf_pkg::step_type step;
   logic walk_start, advance, walk_done;
   logic signed [33:0] anti;
   logic signed [31:0] result;

   assign nx = (cols_ff < 7'd4) ? 8'd4 : (cols_ff > 7'(sgf_pkg::MaxCols))
      ? 8'(sgf_pkg::MaxCols) : {1'b0, cols_ff};
   assign ny = (rows_ff < 7'd4) ? 8'd4 : (rows_ff > 7'(sgf_pkg::MaxRows))
      ? 8'(sgf_pkg::MaxRows) : {1'b0, rows_ff};
   assign bad = ({1'b0, req_data.col} >= nx + 8'(2 * sgf_pkg::Ghost))
      || ({1'b0, req_data.row} >= ny + 8'(2 * sgf_pkg::Ghost));

   sgf_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .start      (walk_start),
      .advance    (advance),
      .grid_kind  (grid_kind_ff),
      .side_modes (side_modes_ff),
      .nx         (nx),
      .ny         (ny),
      .side_value (side_value_ff),
      .step       (step),
      .done       (walk_done)
   );

   sgf_ram #(.Width(32), .Depth(sgf_pkg::Depth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign anti = 34'(step_ff.c) * 34'sd2 - 34'(signed'(rd_data));
   always_comb begin
      if (step_ff.op == sgf_pkg::OP_PUT) begin
         result = step_ff.c;
      end else if (step_ff.op == sgf_pkg::OP_COPY) begin
         result = signed'(rd_data);
      end else if (anti > 34'sh7fffffff) begin
         result = 32'sh7fffffff;
      end else if (anti < -34'sh80000000) begin
         result = 32'sh80000000;
      end else begin
         result = anti[31:0];
      end
   end

   assign walk_start = (state_ff == IDLE) && start && (req_data.kind == sgf_pkg::KIND_APPLY);
   assign advance = (state_ff == WALK_RD && !step.valid) || (state_ff == WALK_WR);

   always_comb begin
      wr_en = 1'b0;
      wr_addr = sgf_pkg::cell_addr({1'b0, req_data.col}, {1'b0, req_data.row});
      wr_data = req_data.cell_value;
      rd_addr = sgf_pkg::cell_addr({1'b0, req_data.col}, {1'b0, req_data.row});
      if (state_ff == IDLE) begin
         wr_en = start && (req_data.kind == sgf_pkg::KIND_WRITE) && !bad;
      end else begin
         rd_addr = sgf_pkg::cell_addr(step.si, step.sj);
         wr_addr = sgf_pkg::cell_addr(step_ff.di, step_ff.dj);
         wr_data = result;
         wr_en = (state_ff == WALK_WR) && step_ff.valid
            && sgf_pkg::inside_pad(step_ff.di, step_ff.dj);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: if (start) begin
            state_in = (req_data.kind == sgf_pkg::KIND_APPLY) ? WALK_RD : ACCESS;
         end
         ACCESS: state_in = IDLE;
         WALK_RD: begin
            if (step.valid) state_in = WALK_WAIT;
            else if (walk_done) state_in = FINISH;
         end
         WALK_WAIT: state_in = WALK_WR;
         WALK_WR: state_in = walk_done ? FINISH : WALK_RD;
         FINISH: state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         grid_kind_ff <= 2'd2;
         side_modes_ff <= '0;
         cols_ff <= 7'd64;
         rows_ff <= 7'd64;
         for (int k = 0; k < 4; k++) side_value_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               sgf_pkg::REG_GRID_KIND: grid_kind_ff <= csr_data[1:0];
               sgf_pkg::REG_SIDE_MODES: side_modes_ff <= csr_data[7:0];
               sgf_pkg::REG_COLS: cols_ff <= csr_data[6:0];
               sgf_pkg::REG_ROWS: rows_ff <= csr_data[6:0];
               default: side_value_ff[csr_index[1:0]] <= csr_data;
            endcase
         end
         if (state_ff == ACCESS || state_ff == FINISH) begin
            rsp_valid_ff <= 1'b1;
         end
      end
      if (state_ff == IDLE && start) begin
         req_ff <= req_data;
         bad_ff <= bad;
      end
      if (state_ff == WALK_RD) begin
         step_ff <= step;
      end
      if (state_ff == ACCESS || state_ff == FINISH) begin
         rsp_ff.read_value <= (state_ff == ACCESS && req_ff.kind == sgf_pkg::KIND_READ
            && !bad_ff) ? signed'(rd_data) : '0;
         rsp_ff.position_error <= (state_ff == ACCESS) && bad_ff
            && (req_ff.kind == sgf_pkg::KIND_READ || req_ff.kind == sgf_pkg::KIND_WRITE);
      end
   end

   assign busy = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not leave idle");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_no_write_when_reading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK_WAIT) |-> !wr_en)
      else $error("store written while a fill read is in flight");
endmodule

[rtl/sgf_ram.sv]
module sgf_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/sgf_walker.sv]
module sgf_walker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                advance,
   input  logic [1:0]          grid_kind,
   input  logic [7:0]          side_modes,
   input  logic [7:0]          nx,
   input  logic [7:0]          ny,
   input  logic signed [31:0]  side_value [4],
   output sgf_pkg::step_type   step,
   output logic                done
);
   typedef enum logic [1:0] {
      IDLE,
      RUN
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] side_ff, side_in;
   logic phase_ff, phase_in;
   logic [7:0] i_ff, i_in, j_ff, j_in;

   logic [1:0] m;
   logic signed [31:0] c;
   logic [7:0] g;
   logic [7:0] ilo, ihi, jlo, jhi;
   logic skip;
   logic last_step;
   logic [7:0] inner, outer, inner_hi, outer_hi, inner_lo, outer_lo;

   assign g = 8'(sgf_pkg::Ghost);
   assign m = side_modes[2*side_ff +: 2];
   assign c = side_value[side_ff];

   // loop bounds of the current phase: i over [ilo,ihi), j over [jlo,jhi)
   always_comb begin
      ilo = '0; ihi = '0; jlo = '0; jhi = '0;
      skip = (m == sgf_pkg::MODE_NONE) || (grid_kind == 2'd3);
      if (!side_ff[1]) begin
         if (grid_kind == 2'd0) begin
            if (m == sgf_pkg::MODE_PERIODIC) begin
               skip = skip || phase_ff;
               ilo = side_ff[0] ? 8'd0 : 8'd0;
               ihi = side_ff[0] ? g : g + 8'd1;
               jlo = g; jhi = ny + g;
            end else if (!phase_ff) begin
               ilo = 8'd0; ihi = 8'd1;
               jlo = 8'd0; jhi = ny + 8'd2 * g;
            end else begin
               ilo = side_ff[0] ? 8'd1 : 8'd0; ihi = g;
               jlo = (m == sgf_pkg::MODE_MIRROR) ? g : 8'd0;
               jhi = (m == sgf_pkg::MODE_MIRROR) ? ny + g + 8'd1 : ny + 8'd2 * g;
            end
         end else begin
            skip = skip || phase_ff;
            ilo = 8'd0; ihi = g;
            jlo = (grid_kind == 2'd1) ? g + 8'd1 : g; jhi = ny + g;
         end
      end else begin
         if (grid_kind == 2'd1) begin
            if (m == sgf_pkg::MODE_PERIODIC) begin
               skip = skip || phase_ff;
               ilo = g; ihi = nx + g;
               jlo = 8'd0; jhi = side_ff[0] ? g : g + 8'd1;
            end else if (!phase_ff) begin
               ilo = 8'd0; ihi = nx + 8'd2 * g;
               jlo = 8'd0; jhi = 8'd1;
            end else begin
               ilo = 8'd0; ihi = nx + 8'd2 * g;
               jlo = side_ff[0] ? 8'd1 : 8'd0; jhi = g;
            end
         end else begin
            skip = skip || phase_ff;
            ilo = (grid_kind == 2'd0 && m != sgf_pkg::MODE_FIXED) ? g + 8'd1 : g;
            ihi = nx + g;
            jlo = 8'd0; jhi = g;
         end
      end
      if (ilo >= ihi || jlo >= jhi) begin
         skip = 1'b1;
      end
   end

   // west/east loops run i outer, j inner; south/north too
   always_comb begin
      outer = i_ff; inner = j_ff;
      outer_lo = ilo; outer_hi = ihi; inner_lo = jlo; inner_hi = jhi;
   end

   assign last_step = (inner + 8'd1 >= inner_hi) && (outer + 8'd1 >= outer_hi);

   // the step for indices i_ff, j_ff
   always_comb begin
      step = '0;
      step.valid = (state_ff == RUN) && !skip && (i_ff >= ilo) && (j_ff >= jlo);
      step.c = c;
      step.op = (m == sgf_pkg::MODE_FIXED) ? sgf_pkg::OP_ANTI : sgf_pkg::OP_COPY;
      if (!side_ff[1]) begin
         step.dj = j_ff; step.sj = j_ff;
         if (grid_kind == 2'd0) begin
            if (m == sgf_pkg::MODE_PERIODIC) begin
               step.op = sgf_pkg::OP_COPY;
               step.di = side_ff[0] ? nx + g + i_ff : i_ff;
               step.si = side_ff[0] ? g + i_ff : nx - 8'd1 + i_ff;
            end else if (!phase_ff) begin
               step.di = side_ff[0] ? nx + g : g;
               step.si = side_ff[0] ? nx + g - 8'd1 : g + 8'd1;
               step.op = (m == sgf_pkg::MODE_MIRROR) ? sgf_pkg::OP_COPY : sgf_pkg::OP_PUT;
            end else begin
               step.di = side_ff[0] ? nx + 8'd2 * g - i_ff : i_ff;
               step.si = side_ff[0] ? nx + i_ff : 8'd2 * g - i_ff;
            end
         end else begin
            if (m == sgf_pkg::MODE_PERIODIC) begin
               step.op = sgf_pkg::OP_COPY;
               step.di = side_ff[0] ? nx + g + i_ff : i_ff;
               step.si = side_ff[0] ? g + i_ff : nx + i_ff;
            end else begin
               step.di = side_ff[0] ? nx + 8'd2 * g - i_ff - 8'd1 : i_ff;
               step.si = side_ff[0] ? nx + i_ff : 8'd2 * g - i_ff - 8'd1;
            end
         end
      end else begin
         step.di = i_ff; step.si = i_ff;
         if (grid_kind == 2'd1) begin
            if (m == sgf_pkg::MODE_PERIODIC) begin
               step.op = sgf_pkg::OP_COPY;
               step.dj = side_ff[0] ? ny + j_ff + g : j_ff;
               step.sj = side_ff[0] ? j_ff + g : ny - 8'd1 + j_ff;
            end else if (!phase_ff) begin
               step.dj = side_ff[0] ? ny + g : g;
               step.sj = side_ff[0] ? ny + g - 8'd1 : g + 8'd1;
               step.op = (m == sgf_pkg::MODE_MIRROR) ? sgf_pkg::OP_COPY : sgf_pkg::OP_PUT;
            end else begin
               step.dj = side_ff[0] ? ny + 8'd2 * g - j_ff : j_ff;
               step.sj = side_ff[0] ? ny + j_ff : 8'd2 * g - j_ff;
            end
         end else begin
            if (m == sgf_pkg::MODE_PERIODIC) begin
               step.op = sgf_pkg::OP_COPY;
               step.dj = side_ff[0] ? ny + j_ff + g : j_ff;
               step.sj = side_ff[0] ? j_ff + g : ny + j_ff;
            end else begin
               step.dj = side_ff[0] ? ny + 8'd2 * g - j_ff - 8'd1 : j_ff;
               step.sj = side_ff[0] ? ny + j_ff : 8'd2 * g - j_ff - 8'd1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      side_in = side_ff;
      phase_in = phase_ff;
      i_in = i_ff;
      j_in = j_ff;
      done = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               state_in = RUN;
               side_in = 2'd0;
               phase_in = 1'b0;
               i_in = 8'd0;
               j_in = 8'd0;
            end
         end
         RUN: begin
            if (advance) begin
               if (skip || last_step) begin
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                  end else begin
                     phase_in = 1'b0;
                     side_in = side_ff + 2'd1;
                     if (side_ff == 2'd3) begin
                        state_in = IDLE;
                        done = 1'b1;
                     end
                  end
                  i_in = 8'hff;
                  j_in = 8'hff;
               end else if (inner + 8'd1 >= inner_hi) begin
                  i_in = outer + 8'd1;
                  j_in = inner_lo;
               end else begin
                  i_in = (outer < outer_lo) ? outer_lo : outer;
                  j_in = inner + 8'd1;
               end
               // a fresh phase starts at index zero
               if (i_in == 8'hff) begin
                  i_in = 8'd0;
                  j_in = 8'd0;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // fresh phase indices are raised to the lower bounds before use
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         side_ff <= '0;
         phase_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         state_ff <= state_in;
         side_ff <= side_in;
         phase_ff <= phase_in;
         if (state_ff == RUN && advance && !(skip || last_step) && i_ff < ilo) begin
            i_ff <= ilo;
            j_ff <= jlo;
         end else if (state_ff == RUN && advance && !(skip || last_step)
                      && j_ff < jlo) begin
            i_ff <= i_ff;
            j_ff <= jlo;
         end else begin
            i_ff <= i_in;
            j_ff <= j_in;
         end
      end
   end
endmodule

[dv/staggered_grid_ghost_cell_fill_tb.sv]
module staggered_grid_ghost_cell_fill_tb;
   import sgf_pkg::*;

   localparam int WatchLimit = 200000;
   localparam int ItemGoal = 1150;
   localparam int QuietFrom = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   staggered_grid_ghost_cell_fill dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // shadow of the padded field and of the registers
   logic signed [31:0] field_mem [PadCols][PadRows];
   bit loaded [PadCols][PadRows];
   logic [1:0] grid_kind_q;
   logic [7:0] side_modes_q;
   logic [6:0] cols_q, rows_q;
   logic signed [31:0] side_val_q [4];

   rsp_type pending_rsp [$];
   int mismatches = 0;
   int items_sent = 0;
   int rsp_seen = 0;
   int applies_sent = 0;
   int phases_done = 0;
   int idle_cycles = 0;
   bit quiet = 0;

   function automatic int eff_cols();
      if (cols_q < 4) return 4;
      if (cols_q > MaxCols) return MaxCols;
      return int'(cols_q);
   endfunction

   function automatic int eff_rows();
      if (rows_q < 4) return 4;
      if (rows_q > MaxRows) return MaxRows;
      return int'(rows_q);
   endfunction

   function automatic logic signed [31:0] get_cell(int i, int j);
      if (i < 0 || j < 0 || i >= PadCols || j >= PadRows) return '0;
      return field_mem[i][j];
   endfunction

   function automatic void put_cell(int i, int j, logic signed [31:0] v);
      if (i < 0 || j < 0 || i >= PadCols || j >= PadRows) return;
      field_mem[i][j] = v;
      loaded[i][j] = 1'b1;
   endfunction

   function automatic void copy_cell(int di, int dj, int si, int sj);
      put_cell(di, dj, get_cell(si, sj));
   endfunction

   // fixed mode gives 2c minus source, saturated
   function automatic void reflect_cell(int di, int dj, int si, int sj, logic [1:0] m,
                                        logic signed [31:0] c);
      longint t;
      if (m != MODE_FIXED) begin
         copy_cell(di, dj, si, sj);
         return;
      end
      t = 2 * longint'(c) - longint'(get_cell(si, sj));
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      put_cell(di, dj, t[31:0]);
   endfunction

   function automatic void fill_we(bit east, logic [1:0] m, logic signed [31:0] c,
                                   int nx, int ny);
      int g, jlo, jhi, j0;
      g = Ghost;
      if (grid_kind_q == 2'd0) begin
         j0 = (m == MODE_MIRROR) ? g : 0;
         jhi = (m == MODE_MIRROR) ? ny + g + 1 : ny + 2 * g;
         if (!east) begin
            if (m == MODE_PERIODIC) begin
               for (int i = 0; i <= g; i++)
                  for (int j = g; j < ny + g; j++) copy_cell(i, j, nx - 1 + i, j);
            end else begin
               for (int j = 0; j < ny + 2 * g; j++)
                  if (m == MODE_MIRROR) copy_cell(g, j, g + 1, j);
                  else put_cell(g, j, c);
               for (int i = 0; i < g; i++)
                  for (int j = j0; j < jhi; j++) reflect_cell(i, j, 2 * g - i, j, m, c);
            end
         end else begin
            if (m == MODE_PERIODIC) begin
               for (int i = 0; i < g; i++)
                  for (int j = g; j < ny + g; j++) copy_cell(nx + g + i, j, g + i, j);
            end else begin
               for (int j = 0; j < ny + 2 * g; j++)
                  if (m == MODE_MIRROR) copy_cell(nx + g, j, nx + g - 1, j);
                  else put_cell(nx + g, j, c);
               for (int i = 1; i < g; i++)
                  for (int j = j0; j < jhi; j++)
                     reflect_cell(nx + 2 * g - i, j, nx + i, j, m, c);
            end
         end
         return;
      end
      jlo = (grid_kind_q == 2'd1) ? g + 1 : g;
      for (int i = 0; i < g; i++)
         for (int j = jlo; j < ny + g; j++) begin
            if (!east) begin
               if (m == MODE_PERIODIC) copy_cell(i, j, nx + i, j);
               else reflect_cell(i, j, 2 * g - i - 1, j, m, c);
            end else begin
               if (m == MODE_PERIODIC) copy_cell(nx + g + i, j, g + i, j);
               else reflect_cell(nx + 2 * g - i - 1, j, nx + i, j, m, c);
            end
         end
   endfunction

   function automatic void fill_sn(bit north, logic [1:0] m, logic signed [31:0] c,
                                   int nx, int ny);
      int g, ilo;
      g = Ghost;
      if (grid_kind_q == 2'd1) begin
         if (m == MODE_PERIODIC) begin
            for (int i = g; i < nx + g; i++)
               if (!north)
                  for (int j = 0; j <= g; j++) copy_cell(i, j, i, ny - 1 + j);
               else
                  for (int j = 0; j < g; j++) copy_cell(i, ny + j + g, i, j + g);
            return;
         end
         for (int i = 0; i < nx + 2 * g; i++) begin
            if (!north) begin
               if (m == MODE_MIRROR) copy_cell(i, g, i, g + 1);
               else put_cell(i, g, c);
            end else begin
               if (m == MODE_MIRROR) copy_cell(i, ny + g, i, ny + g - 1);
               else put_cell(i, ny + g, c);
            end
         end
         for (int i = 0; i < nx + 2 * g; i++)
            if (!north)
               for (int j = 0; j < g; j++) reflect_cell(i, j, i, 2 * g - j, m, c);
            else
               for (int j = 1; j < g; j++) reflect_cell(i, ny + 2 * g - j, i, ny + j, m, c);
         return;
      end
      ilo = (grid_kind_q == 2'd0 && m != MODE_FIXED) ? g + 1 : g;
      for (int i = ilo; i < nx + g; i++)
         for (int j = 0; j < g; j++) begin
            if (!north) begin
               if (m == MODE_PERIODIC) copy_cell(i, j, i, ny + j);
               else reflect_cell(i, j, i, 2 * g - j - 1, m, c);
            end else begin
               if (m == MODE_PERIODIC) copy_cell(i, ny + j + g, i, j + g);
               else reflect_cell(i, ny + 2 * g - j - 1, i, ny + j, m, c);
            end
         end
   endfunction

   function automatic void fill_ghosts();
      logic [1:0] m;
      if (grid_kind_q > 2'd2) return;
      for (int s = 0; s < 4; s++) begin
         m = side_modes_q[2 * s +: 2];
         if (m == MODE_NONE) continue;
         if (s < 2) fill_we(s == 1, m, side_val_q[s], eff_cols(), eff_rows());
         else fill_sn(s == 3, m, side_val_q[s], eff_cols(), eff_rows());
      end
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      bit bad;
      o = '0;
      bad = (r.col >= eff_cols() + 2 * Ghost) || (r.row >= eff_rows() + 2 * Ghost);
      case (r.kind)
         KIND_WRITE: begin
            if (bad) o.position_error = 1'b1;
            else put_cell(r.col, r.row, r.cell_value);
         end
         KIND_APPLY: fill_ghosts();
         KIND_READ: begin
            if (bad) o.position_error = 1'b1;
            else o.read_value = get_cell(r.col, r.row);
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic bit grid_loaded();
      for (int i = 0; i < eff_cols() + 2 * Ghost; i++)
         for (int j = 0; j < eff_rows() + 2 * Ghost; j++)
            if (!loaded[i][j]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // called straight after a rising edge
   task automatic issue(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type p;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      p = predict_rsp(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
      items_sent++;
      if (r.kind == KIND_APPLY) applies_sent++;
   endtask

   task automatic send(logic [1:0] k, int c, int rw, logic [31:0] v);
      req_type r;
      r.kind = k;
      r.col = 7'(c);
      r.row = 7'(rw);
      r.cell_value = v;
      issue(r, 1'b0, '0);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      case (idx)
         REG_GRID_KIND: grid_kind_q = v[1:0];
         REG_SIDE_MODES: side_modes_q = v[7:0];
         REG_COLS: cols_q = v[6:0];
         REG_ROWS: rows_q = v[6:0];
         default: side_val_q[idx - 4] = v;
      endcase
   endtask

   typedef struct {
      req_type r;
      bit typed;
      rsp_type e;
   } directed_row;

   directed_row directed [] = '{
      '{'{KIND_WRITE, 7'd0, 7'd0, 32'sh7fff_ffff}, 1'b1, '{32'sd0, 1'b0}},
      '{'{KIND_READ, 7'd0, 7'd0, 32'sd0}, 1'b1, '{32'sh7fff_ffff, 1'b0}},
      '{'{KIND_WRITE, 7'd69, 7'd69, 32'sh8000_0000}, 1'b1, '{32'sd0, 1'b0}},
      '{'{KIND_READ, 7'd69, 7'd69, 32'shffff_ffff}, 1'b1, '{32'sh8000_0000, 1'b0}},
      '{'{KIND_WRITE, 7'd70, 7'd3, 32'sh1234_5678}, 1'b1, '{32'sd0, 1'b1}},
      '{'{KIND_WRITE, 7'd3, 7'd70, 32'sh1234_5678}, 1'b1, '{32'sd0, 1'b1}},
      '{'{KIND_READ, 7'd3, 7'd127, 32'sd0}, 1'b1, '{32'sd0, 1'b1}},
      '{'{KIND_READ, 7'd127, 7'd127, 32'sd0}, 1'b1, '{32'sd0, 1'b1}},
      '{'{2'd3, 7'd127, 7'd127, 32'shffff_ffff}, 1'b1, '{32'sd0, 1'b0}},
      '{'{KIND_APPLY, 7'd127, 7'd0, 32'shffff_ffff}, 1'b1, '{32'sd0, 1'b0}},
      '{'{KIND_READ, 7'd0, 7'd0, 32'sd0}, 1'b1, '{32'sh7fff_ffff, 1'b0}},
      '{'{KIND_WRITE, 7'd35, 7'd42, 32'sh5555_aaaa}, 1'b0, '0},
      '{'{KIND_READ, 7'd35, 7'd42, 32'sd0}, 1'b0, '0},
      '{'{KIND_WRITE, 7'd69, 7'd0, 32'sh0000_0001}, 1'b0, '0},
      '{'{KIND_READ, 7'd69, 7'd0, 32'sd0}, 1'b0, '0}
   };

   // results cannot be held off, so check every strobe
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.read_value !== want.read_value ||
                rsp_data.position_error !== want.position_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: read_value exp %h got %h, position_error exp %b got %b",
                           want.read_value, rsp_data.read_value,
                           want.position_error, rsp_data.position_error);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("watchdog expired with %0d transfers outstanding", pending_rsp.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int nc, nr, op, ci, ri;
      grid_kind_q = 2'd2;
      side_modes_q = 8'h00;
      cols_q = 7'd64;
      rows_q = 7'd64;
      for (int s = 0; s < 4; s++) side_val_q[s] = '0;
      foreach (loaded[i, j]) loaded[i][j] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) issue(directed[k].r, directed[k].typed, directed[k].e);

      while (items_sent < ItemGoal) begin
         drain();
         case (phases_done)
            0: begin nc = 127; nr = 4; end
            1: begin nc = 0; nr = 64; end
            2: begin nc = 4; nr = 4; end
            default: begin nc = $urandom_range(4, 9); nr = $urandom_range(4, 9); end
         endcase
         if (phases_done == 1) nr = 5;
         csr_write(REG_GRID_KIND, (phases_done == 5) ? 32'd3 : 32'(phases_done % 3));
         csr_write(REG_SIDE_MODES, (phases_done == 2) ? 32'hff :
                   (phases_done == 3) ? 32'h00 : 32'($urandom_range(0, 255)));
         csr_write(REG_COLS, 32'(nc));
         csr_write(REG_ROWS, 32'(nr));
         for (int s = 4; s < 8; s++) csr_write(3'(s), pick_value());
         csr_we <= 1'b0;
         @(posedge clock);
         if (phases_done >= 6) quiet = (items_sent >= QuietFrom);

         if (!grid_loaded())
            for (int i = 0; i < eff_cols() + 2 * Ghost; i++)
               for (int j = 0; j < eff_rows() + 2 * Ghost; j++)
                  if (!loaded[i][j]) send(KIND_WRITE, i, j, pick_value());

         repeat (60) begin
            op = $urandom_range(0, 99);
            ci = $urandom_range(0, eff_cols() + 2 * Ghost - 1);
            ri = $urandom_range(0, eff_rows() + 2 * Ghost - 1);
            if (op < 45) send(KIND_READ, ci, ri, $urandom);
            else if (op < 70) send(KIND_WRITE, ci, ri, pick_value());
            else if (op < 82) send(KIND_APPLY, $urandom_range(0, 127),
                                   $urandom_range(0, 127), $urandom);
            else if (op < 94) send(($urandom_range(0, 1) ? KIND_READ : KIND_WRITE),
                                   $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
            else send(2'd3, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
         end
         phases_done++;
      end
      drain();
      $display("%0d items over %0d register settings, %0d boundary fills, %0d results checked",
               items_sent, phases_done, applies_sent, rsp_seen);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
